// ----- hdl/hfu_pkg.sv -----
// Shared types and constants of the header field unfolding parser.
// No dependencies; used by the output queue and the top level.
`default_nettype none

package hfu_pkg;

    // result kinds
    localparam logic [2:0] K_NAME  = 3'd0;
    localparam logic [2:0] K_VALUE = 3'd1;
    localparam logic [2:0] K_FEND  = 3'd2;
    localparam logic [2:0] K_DONE  = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // error codes
    localparam logic [1:0] E_UNTERM  = 2'd0;
    localparam logic [1:0] E_NOVALUE = 2'd1;
    localparam logic [1:0] E_TOOMANY = 2'd2;

    // characters
    localparam logic [7:0] C_NUL   = 8'd0;
    localparam logic [7:0] C_TAB   = 8'd9;
    localparam logic [7:0] C_LF    = 8'd10;
    localparam logic [7:0] C_CR    = 8'd13;
    localparam logic [7:0] C_SP    = 8'd32;
    localparam logic [7:0] C_COLON = 8'd58;
    localparam logic [7:0] C_UPA   = 8'd65;
    localparam logic [7:0] C_UPZ   = 8'd90;
    localparam logic [7:0] C_CASE  = 8'd32;

    localparam logic [15:0] MAX_FIELDS_RST = 16'd5000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_char;
        logic [1:0] error_code;
        logic       last;
    } t_res;

    // results of one byte, handed to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        t_res       e0;
        t_res       e1;
    } t_push;

endpackage

`default_nettype wire

// ----- hdl/hfu_if.sv -----
// Channel interfaces of the parser: input bytes, config writes, results.
// Depends on nothing but plain logic types.
`default_nettype none

interface hfu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface hfu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_fields;
    modport source (output valid, output max_fields, input ready);
    modport sink   (input valid, input max_fields, output ready);
endinterface

interface hfu_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_char;
    logic [1:0] error_code;
    logic       last;
    modport source (output valid, output kind, output out_char, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_char, input error_code,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/hfu_outq.sv -----
// Result queue: in, up to two results per cycle; out, one per ready cycle.
// Depends on hfu_pkg and hfu_out_if.
`default_nettype none

module hfu_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  hfu_pkg::t_push    i_push,
    output logic              o_room,
    hfu_out_if.source         o_out
);

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    hfu_pkg::t_res r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] wr1;
    logic          pop;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop    = o_out.ready && (r_cnt != '0);
    assign wr1    = nxt(r_wr);
    assign o_room = (r_cnt <= ROOM_MAX);

    always_comb begin
        n_rd  = pop ? nxt(r_rd) : r_rd;
        n_wr  = r_wr;
        if (i_push.cnt == 2'd1) begin
            n_wr = wr1;
        end else if (i_push.cnt == 2'd2) begin
            n_wr = nxt(wr1);
        end
        n_cnt = r_cnt + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr1] <= i_push.e1;
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.kind       = r_mem[r_rd].kind;
    assign o_out.out_char   = r_mem[r_rd].out_char;
    assign o_out.error_code = r_mem[r_rd].error_code;
    assign o_out.last       = r_mem[r_rd].last;

endmodule

`default_nettype wire

// ----- hdl/header_field_unfold_parser.sv -----
// Top level of the header field unfolding parser: byte parser and config register.
// Depends on hfu_pkg, hfu_if and hfu_outq.
// Results are registered in the result queue as their byte is accepted.
// Throughput: one byte per cycle while i_in.ready is high; the output moves one
// result per cycle while o_out.ready; the queue absorbs a byte's second result.
// i_in.ready is high while the result queue has room for two results.
// Reset (synchronous, active low): parser at field start, count cleared,
// max_fields back to 5000, result queue empty.
`default_nettype none

module header_field_unfold_parser #(
    parameter int QDEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hfu_in_if.sink      i_in,
    hfu_cfg_if.sink     i_cfg,
    hfu_out_if.source   o_out
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_VALUE = 3'd2;
    localparam logic [2:0] PH_VEOL  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic        r_seen, n_seen;
    logic        r_pend, n_pend;
    logic        r_raw, n_raw;
    logic [15:0] r_fcount, n_fcount;
    logic [15:0] r_max_fields;

    hfu_pkg::t_push push;
    logic           room;
    logic           acc;
    logic [7:0]     b;
    logic [7:0]     lc;
    logic           b_ws, b_eol, b_blank;

    assign acc        = i_in.valid && room;
    assign i_in.ready = room;
    assign i_cfg.ready = 1'b1;
    assign b          = i_in.in_char;

    assign b_eol   = (b == hfu_pkg::C_LF) || (b == hfu_pkg::C_CR);
    assign b_blank = (b == hfu_pkg::C_SP) || (b == hfu_pkg::C_TAB);
    assign b_ws    = (b == hfu_pkg::C_SP) || ((b >= hfu_pkg::C_TAB) && (b <= hfu_pkg::C_CR));
    assign lc      = ((b >= hfu_pkg::C_UPA) && (b <= hfu_pkg::C_UPZ)) ? b + hfu_pkg::C_CASE : b;

    function automatic hfu_pkg::t_push put(input hfu_pkg::t_push p, input logic [2:0] k,
                                           input logic [7:0] c, input logic [1:0] e);
        hfu_pkg::t_res r;
        r.kind       = k;
        r.out_char   = c;
        r.error_code = e;
        r.last       = 1'b0;
        if (p.cnt == 2'd0) begin
            p.e0 = r;
        end else begin
            p.e1 = r;
        end
        p.cnt = p.cnt + 2'd1;
        return p;
    endfunction

    always_comb begin
        logic [15:0] fc;
        logic        do_start;
        logic [7:0]  tc;
        logic [2:0]  tk;
        logic        do_text;

        n_phase  = r_phase;
        n_seen   = r_seen;
        n_pend   = r_pend;
        n_raw    = r_raw;
        n_fcount = r_fcount;
        push     = '0;
        fc       = r_fcount;
        do_start = 1'b0;
        do_text  = 1'b0;
        tc       = b;
        tk       = hfu_pkg::K_VALUE;

        unique case (r_phase)
            PH_START: begin
                do_start = 1'b1;
            end
            PH_NAME: begin
                if (b == hfu_pkg::C_NUL) begin
                    push    = put(push, hfu_pkg::K_ERR, 8'd0, hfu_pkg::E_UNTERM);
                    n_phase = PH_START;
                    n_seen  = 1'b0;
                    n_pend  = 1'b0;
                    n_raw   = 1'b0;
                    n_fcount = '0;
                end else if (b == hfu_pkg::C_COLON || b_eol) begin
                    n_phase = PH_VALUE;
                    n_seen  = 1'b0;
                    n_pend  = 1'b0;
                    n_raw   = 1'b0;
                end else begin
                    do_text = 1'b1;
                    tk      = hfu_pkg::K_NAME;
                    tc      = lc;
                end
            end
            PH_VALUE: begin
                if (b == hfu_pkg::C_NUL) begin
                    push    = put(push, hfu_pkg::K_ERR, 8'd0, hfu_pkg::E_UNTERM);
                    n_phase = PH_START;
                    n_seen  = 1'b0;
                    n_pend  = 1'b0;
                    n_raw   = 1'b0;
                    n_fcount = '0;
                end else if (b_eol) begin
                    n_phase = PH_VEOL;
                end else begin
                    n_raw   = 1'b1;
                    do_text = 1'b1;
                end
            end
            PH_VEOL: begin
                if (b_blank) begin
                    // folded line: the line end counts as whitespace
                    n_raw   = 1'b1;
                    n_pend  = r_pend | r_seen;
                    n_phase = PH_VALUE;
                end else if (!r_raw) begin
                    push = put(push, hfu_pkg::K_ERR, 8'd0, hfu_pkg::E_NOVALUE);
                    if (b == hfu_pkg::C_NUL) begin
                        n_phase  = PH_START;
                        n_seen   = 1'b0;
                        n_pend   = 1'b0;
                        n_raw    = 1'b0;
                        n_fcount = '0;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    push     = put(push, hfu_pkg::K_FEND, 8'd0, hfu_pkg::E_UNTERM);
                    fc       = r_fcount + 16'd1;
                    n_fcount = fc;
                    do_start = 1'b1;
                end
            end
            PH_SKIP: begin
                if (b == hfu_pkg::C_NUL) begin
                    n_phase  = PH_START;
                    n_seen   = 1'b0;
                    n_pend   = 1'b0;
                    n_raw    = 1'b0;
                    n_fcount = '0;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        if (do_text) begin
            if (b_ws) begin
                n_pend = r_pend | r_seen;
            end else begin
                if (r_pend) begin
                    push = put(push, tk, hfu_pkg::C_SP, hfu_pkg::E_UNTERM);
                end
                push   = put(push, tk, tc, hfu_pkg::E_UNTERM);
                n_pend = 1'b0;
                n_seen = 1'b1;
            end
        end

        // field start: zero byte, or colon/line end under max_fields, closes the message
        if (do_start) begin
            if (b == hfu_pkg::C_NUL) begin
                push     = put(push, hfu_pkg::K_DONE, 8'd0, hfu_pkg::E_UNTERM);
                n_phase  = PH_START;
                n_seen   = 1'b0;
                n_pend   = 1'b0;
                n_raw    = 1'b0;
                n_fcount = '0;
            end else if (fc >= r_max_fields) begin
                push    = put(push, hfu_pkg::K_ERR, 8'd0, hfu_pkg::E_TOOMANY);
                n_phase = PH_SKIP;
            end else if (b == hfu_pkg::C_COLON || b_eol) begin
                push    = put(push, hfu_pkg::K_DONE, 8'd0, hfu_pkg::E_UNTERM);
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_NAME;
                n_pend  = 1'b0;
                n_seen  = !b_ws;
                if (!b_ws) begin
                    push = put(push, hfu_pkg::K_NAME, lc, hfu_pkg::E_UNTERM);
                end
            end
        end

        push.e0.last = (push.cnt == 2'd1);
        push.e1.last = 1'b1;
        if (!acc) begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_seen       <= 1'b0;
            r_pend       <= 1'b0;
            r_raw        <= 1'b0;
            r_fcount     <= '0;
            r_max_fields <= hfu_pkg::MAX_FIELDS_RST;
        end else begin
            if (acc) begin
                r_phase  <= n_phase;
                r_seen   <= n_seen;
                r_pend   <= n_pend;
                r_raw    <= n_raw;
                r_fcount <= n_fcount;
            end
            if (i_cfg.valid) begin
                r_max_fields <= i_cfg.max_fields;
            end
        end
    end

    hfu_outq #(
        .DEPTH (QDEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

    // a zero byte always leaves the parser at the start of a new message
    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && b == hfu_pkg::C_NUL) |=> (r_phase == PH_START && r_fcount == 16'd0))
        else $error("zero byte did not restart the message");

    // a pending space only exists after text in the current name or value
    a_pend_needs_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_seen)
        else $error("pending space without text");

    a_char_only_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != hfu_pkg::K_NAME && o_out.kind != hfu_pkg::K_VALUE)
        |-> (o_out.out_char == 8'd0))
        else $error("character on a non-text result");

    a_code_only_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != hfu_pkg::K_ERR) |-> (o_out.error_code == 2'd0))
        else $error("error code on a non-error result");

endmodule

`default_nettype wire
